@@ design/max_unpool_scatter_assert.svh @@
// ----------------------------------------------------------------------------
// Max-unpool scatter assertion macros
// Shared forms for the concurrent checks on the top-level ports.
// ----------------------------------------------------------------------------
`ifndef MAX_UNPOOL_SCATTER_ASSERT_SVH
`define MAX_UNPOOL_SCATTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define MUP_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define MUP_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ design/mup_pkg.sv @@
// ----------------------------------------------------------------------------
// Max-unpool scatter package
// Types, sizes and item codes shared by the scatter engine modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mup_pkg;

    // Store geometry.
    localparam int STORE_DEPTH = 65536;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Element count register.
    localparam int          ELEMS_W     = 17;
    localparam logic [16:0] ELEMS_RESET = 17'd65536;

    // Item kinds.
    localparam logic [1:0] KIND_CLEAR   = 2'd0;
    localparam logic [1:0] KIND_SCATTER = 2'd1;
    localparam logic [1:0] KIND_READ    = 2'd2;

    // Input item.
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] flat_index;
        logic [31:0]        value_bits;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [31:0] read_bits;
        logic        status;
    } t_out_item;

    // Decoded item handed from the bounds logic to the controller.
    typedef struct packed {
        logic [1:0]        kind;
        logic              in_range;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       value;
    } t_item_dec;

    // One store access.
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       wdata;
    } t_mem_req;

endpackage

@@ design/mup_store.sv @@
// ----------------------------------------------------------------------------
// Max-unpool output store
// Single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mup_store
    import mup_pkg::*;
(
    input  logic        i_clk,
    input  t_mem_req    i_req,
    output logic [31:0] o_rdata
);

    logic [31:0] r_mem [STORE_DEPTH];
    logic [31:0] r_rdata;

    // Write on request, otherwise read the addressed word.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end else begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/mup_ctrl.sv @@
// ----------------------------------------------------------------------------
// Max-unpool scatter controller
// Sequences store accesses, the zero-fill sweep and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mup_ctrl
    import mup_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_item_dec   i_dec,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    output t_mem_req    o_mem_req,
    input  logic [31:0] i_mem_rdata
);

    typedef enum logic {
        ST_SWEEP,
        ST_RUN
    } t_state;

    t_state            r_state, n_state;
    logic [ADDR_W-1:0] r_sweep_addr, n_sweep_addr;
    logic              r_pend, n_pend;
    logic              r_pend_read, n_pend_read;
    logic              r_pend_status, n_pend_status;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out_item, n_out_item;
    logic              r_skid_valid, n_skid_valid;
    t_out_item         r_skid_item, n_skid_item;

    logic      in_ready;
    logic      in_accept;
    logic      out_free;
    t_out_item pend_item;

    // An item enters only when no earlier item is in flight and the skid
    // register is empty, so its result always has a place to land.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign in_ready   = (r_state == ST_RUN) && !r_pend && !r_skid_valid;
    assign in_accept  = i_in_valid && in_ready;
    assign o_in_stall = !in_ready;

    // Store access: sweep writes zeros, scatter writes, read addresses.
    always_comb begin
        o_mem_req.we    = 1'b0;
        o_mem_req.addr  = i_dec.addr;
        o_mem_req.wdata = i_dec.value;
        if (r_state == ST_SWEEP) begin
            o_mem_req.we    = 1'b1;
            o_mem_req.addr  = r_sweep_addr;
            o_mem_req.wdata = '0;
        end else if (in_accept && (i_dec.kind == KIND_SCATTER) && i_dec.in_range) begin
            o_mem_req.we = 1'b1;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state       = r_state;
        n_sweep_addr  = r_sweep_addr;
        n_pend        = 1'b0;
        n_pend_read   = r_pend_read;
        n_pend_status = r_pend_status;
        n_out_valid   = r_out_valid;
        n_out_item    = r_out_item;
        n_skid_valid  = r_skid_valid;
        n_skid_item   = r_skid_item;

        // Result of the item accepted in the cycle before.
        pend_item.read_bits = r_pend_read ? i_mem_rdata : 32'd0;
        pend_item.status    = r_pend_status;

        // Zero-fill sweep, one word a cycle.
        if (r_state == ST_SWEEP) begin
            n_sweep_addr = r_sweep_addr + ADDR_W'(1);
            if (r_sweep_addr == ADDR_W'(STORE_DEPTH - 1)) begin
                n_state = ST_RUN;
            end
        end

        // Accepted item: record what its result needs.
        if (in_accept) begin
            n_pend        = 1'b1;
            n_pend_read   = 1'b0;
            n_pend_status = 1'b0;
            case (i_dec.kind)
                KIND_CLEAR: begin
                    n_state      = ST_SWEEP;
                    n_sweep_addr = '0;
                end
                KIND_SCATTER: begin
                    n_pend_status = !i_dec.in_range;
                end
                KIND_READ: begin
                    n_pend_read   = i_dec.in_range;
                    n_pend_status = !i_dec.in_range;
                end
                default: begin
                end
            endcase
        end

        // Result register drains on take and refills from the skid register
        // first, then from the pending item; a blocked pending item parks in
        // the skid register.
        if (out_free) begin
            n_out_valid = 1'b0;
            if (r_skid_valid) begin
                n_out_valid  = 1'b1;
                n_out_item   = r_skid_item;
                n_skid_valid = 1'b0;
            end else if (r_pend) begin
                n_out_valid = 1'b1;
                n_out_item  = pend_item;
            end
        end else if (r_pend) begin
            n_skid_valid = 1'b1;
            n_skid_item  = pend_item;
        end
    end

    // State and registered outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_SWEEP;
            r_sweep_addr <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_sweep_addr <= n_sweep_addr;
            r_pend       <= n_pend;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
        r_pend_read   <= n_pend_read;
        r_pend_status <= n_pend_status;
        r_out_item    <= n_out_item;
        r_skid_item   <= n_skid_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

@@ design/max_unpool_scatter.sv @@
// ----------------------------------------------------------------------------
// Max-unpool scatter engine
// Scatters, reads and clears 32-bit words in an output store of flat elements.
//
// Usage:
// Input items arrive on i_in_valid / o_in_stall with an i_in_item payload;
// kind 0 clears the store, kind 1 scatters value_bits at flat_index, kind 2
// reads flat_index. Every item yields one result on o_out_valid / i_out_stall:
// read_bits (read data, else zero) and status (1 when a scatter or read index is
// negative or at or beyond the element count or the store depth; such an item
// writes nothing). The element count is loaded through i_cfg_we / i_cfg_wdata;
// the user is to load it while idle, and the block itself does not enforce this.
// A result passes from the pending stage and the store read register into the
// result register. One item is in flight at a time: a new item is not accepted
// while the last one is in the pending stage. A clear item yields its result the
// same way while it sweeps all 65536 store words, one word a cycle, before the
// next item is accepted. After reset the same sweep runs with o_in_stall high;
// configuration writes are taken during it.
// While the receiver stalls, the result holds and at most one more item is
// accepted ahead of it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module max_unpool_scatter
    import mup_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [ELEMS_W-1:0] i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_item
);

    logic [ELEMS_W-1:0] r_elems;
    logic [31:0]        bound;
    t_item_dec          dec;
    t_mem_req           mem_req;
    logic [31:0]        mem_rdata;

    // Element count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elems <= ELEMS_RESET;
        end else if (i_cfg_we) begin
            r_elems <= i_cfg_wdata;
        end
    end

    // Usable bound is the element count, saturated at the store depth.
    assign bound = (32'(r_elems) > 32'(STORE_DEPTH)) ? 32'(STORE_DEPTH) : 32'(r_elems);

    // Index check and decode.
    always_comb begin
        dec.kind     = i_in_item.kind;
        dec.in_range = !i_in_item.flat_index[31] && (32'(i_in_item.flat_index) < bound);
        dec.addr     = i_in_item.flat_index[ADDR_W-1:0];
        dec.value    = i_in_item.value_bits;
    end

    mup_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_dec       (dec),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .o_mem_req   (mem_req),
        .i_mem_rdata (mem_rdata)
    );

    mup_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

endmodule

@@ design/mup_checker.sv @@
// ----------------------------------------------------------------------------
// Max-unpool scatter port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "max_unpool_scatter_assert.svh"

module mup_checker
    import mup_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_cfg_we,
    input logic [ELEMS_W-1:0] i_cfg_wdata,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input t_in_item           i_in_item,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input t_out_item          o_out_item
);

    logic in_acc;
    logic out_free;
    logic clr_acc;
    logic clr_res;
    logic neg_acc;
    logic neg_res;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !o_out_valid || !i_out_stall;

    // Items whose result lands straight in a free result register.
    assign clr_acc = in_acc && out_free && (i_in_item.kind == KIND_CLEAR);
    assign neg_acc = in_acc && out_free && (i_in_item.kind == KIND_SCATTER) &&
                     i_in_item.flat_index[31];
    assign clr_res = o_out_valid && (o_out_item.read_bits == 32'd0) && !o_out_item.status;
    assign neg_res = o_out_valid && o_out_item.status;

    // A stalled result holds.
    `MUP_CHECK_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item), "stalled result changed")

    // Only one item is in flight: the input stalls right after an accept.
    `MUP_CHECK_NEXT(a_one_in_flight, in_acc, o_in_stall, "item accepted while one is in flight")

    // A clear item that enters while the result register is free yields a zero,
    // in-range result once it has passed the pending stage into the result register.
    `MUP_CHECK(a_clear_result, clr_acc, ##2 clr_res, "bad clear result")

    // A negative scatter index is flagged in the result register under the same condition.
    `MUP_CHECK(a_neg_flag, neg_acc, ##2 neg_res, "negative index not flagged")

endmodule

bind max_unpool_scatter mup_checker u_chk (.*);

@@ dv/testbench.sv @@
// ----------------------------------------------------------------------------
// Max-unpool scatter engine testbench
// Drives clear, scatter, read and spare items through the engine and checks every
// result against a typed table result or a behavioral store kept in the bench.
// A short table of directed items covers the index extremes, the bounds flag,
// overwrite order, clears, a zero element count and a saturating count. Random
// phases follow under several element counts, with idle and stall patterns on
// both sides and one long output hold-off that backs the engine up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import mup_pkg::*;

    localparam int         HALF_PERIOD     = 6;
    localparam int         MAX_CYCLES      = 2_000_000;
    localparam int         PHASES          = 8;
    localparam int         ITEMS_PER_PHASE = 150;
    localparam int         PRESSURE_HOLD   = 400;
    localparam int         DRAIN_CYCLES    = 16;
    localparam int         REPORT_LIMIT    = 10;
    localparam int         DIRECTED_ROWS   = 27;
    localparam logic [1:0] KIND_SPARE      = 2'd3;

    localparam t_out_item RES_OK  = '{32'd0, 1'b0};
    localparam t_out_item RES_OOR = '{32'd0, 1'b1};

    // One row of the directed table: an item, or an element count to load.
    typedef struct packed {
        logic        is_cfg;
        logic [1:0]  kind;
        logic [31:0] index;
        logic [31:0] value;
        logic        typed;
        t_out_item   result;
    } t_table_row;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [ELEMS_W-1:0] i_cfg_wdata = '0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    t_in_item           i_in_item   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_item          o_out_item;

    // Behavioral copy of the store and the element count.
    bit [31:0]   unpool_words [int unsigned];
    int unsigned elems_limit = 32'(ELEMS_RESET);
    t_out_item   pending_results [$];

    // Result typed into the table for the item on offer, if any.
    logic      typed_valid  = 1'b0;
    t_out_item typed_result = '0;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        pressure_req   = 1'b0;
    logic        pressure_done  = 1'b0;
    int unsigned hold_left      = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    t_table_row directed_rows [DIRECTED_ROWS] = '{
        // After reset the store is zero and the whole depth is addressable.
        '{1'b0, KIND_READ,    32'd0,         32'd0,         1'b1, RES_OK},
        '{1'b0, KIND_READ,    32'd65535,     32'd0,         1'b1, RES_OK},
        '{1'b0, KIND_READ,    32'd65536,     32'd0,         1'b1, RES_OOR},
        '{1'b0, KIND_READ,    32'hFFFF_FFFF, 32'd0,         1'b1, RES_OOR},
        '{1'b0, KIND_READ,    32'h8000_0000, 32'd0,         1'b1, RES_OOR},
        '{1'b0, KIND_READ,    32'h7FFF_FFFF, 32'd0,         1'b1, RES_OOR},
        // Scatters at both ends, just past the top and below zero.
        '{1'b0, KIND_SCATTER, 32'd0,         32'hFFFF_FFFF, 1'b1, RES_OK},
        '{1'b0, KIND_SCATTER, 32'd65535,     32'h8000_0000, 1'b1, RES_OK},
        '{1'b0, KIND_SCATTER, 32'd65536,     32'h1234_5678, 1'b1, RES_OOR},
        '{1'b0, KIND_SCATTER, 32'hFFFF_FFFB, 32'hDEAD_BEEF, 1'b1, RES_OOR},
        '{1'b0, KIND_READ,    32'd0,         32'd0,         1'b0, RES_OK},
        '{1'b0, KIND_READ,    32'd65535,     32'd0,         1'b0, RES_OK},
        // A later write to the same index wins.
        '{1'b0, KIND_SCATTER, 32'd7,         32'hA5A5_A5A5, 1'b1, RES_OK},
        '{1'b0, KIND_SCATTER, 32'd7,         32'h5A5A_5A5A, 1'b1, RES_OK},
        '{1'b0, KIND_READ,    32'd7,         32'd0,         1'b0, RES_OK},
        // The unused kind leaves the store alone.
        '{1'b0, KIND_SPARE,   32'd7,         32'hFFFF_FFFF, 1'b1, RES_OK},
        '{1'b0, KIND_READ,    32'd7,         32'd0,         1'b0, RES_OK},
        // A clear ignores its index and value.
        '{1'b0, KIND_CLEAR,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, RES_OK},
        '{1'b0, KIND_READ,    32'd0,         32'd0,         1'b1, RES_OK},
        '{1'b0, KIND_READ,    32'd7,         32'd0,         1'b1, RES_OK},
        // With a zero element count every index is out of range.
        '{1'b1, KIND_CLEAR,   32'd0,         32'd0,         1'b0, RES_OK},
        '{1'b0, KIND_READ,    32'd0,         32'd0,         1'b1, RES_OOR},
        '{1'b0, KIND_SCATTER, 32'd0,         32'd1,         1'b1, RES_OOR},
        // A count above the depth saturates to the depth.
        '{1'b1, KIND_CLEAR,   32'd0,         32'd131071,    1'b0, RES_OK},
        '{1'b0, KIND_SCATTER, 32'd65535,     32'h1357_9BDF, 1'b1, RES_OK},
        '{1'b0, KIND_READ,    32'd65535,     32'd0,         1'b0, RES_OK},
        '{1'b0, KIND_READ,    32'd65536,     32'd0,         1'b1, RES_OOR}
    };

    max_unpool_scatter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Applies one item to the behavioral store and returns its expected result.
    function automatic t_out_item unpool_apply(t_in_item item);
        t_out_item   res;
        int unsigned bound;
        int unsigned slot;
        bit          in_range;
        res      = '0;
        bound    = (elems_limit > STORE_DEPTH) ? STORE_DEPTH : elems_limit;
        slot     = 32'(item.flat_index[30:0]);
        in_range = !item.flat_index[31] && (slot < bound);
        case (item.kind)
            KIND_CLEAR: begin
                unpool_words.delete();
            end
            KIND_SCATTER: begin
                if (in_range) begin
                    unpool_words[slot] = item.value_bits;
                end else begin
                    res.status = 1'b1;
                end
            end
            KIND_READ: begin
                if (!in_range) begin
                    res.status = 1'b1;
                end else if (unpool_words.exists(slot)) begin
                    res.read_bits = unpool_words[slot];
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    // Index mix: mostly in range near both ends, some just out, negative or wild.
    function automatic logic [31:0] pick_index(int unsigned bound);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (bound == 0) begin
            roll = 75 + (roll % 25);
        end
        if (roll < 40) begin
            return $urandom_range(0, ((bound < 48) ? bound : 48) - 1);
        end else if (roll < 60) begin
            return bound - 1 - $urandom_range(0, ((bound < 16) ? bound : 16) - 1);
        end else if (roll < 75) begin
            return $urandom_range(0, bound - 1);
        end else if (roll < 85) begin
            return bound + $urandom_range(0, 3);
        end else if (roll < 93) begin
            return 32'd0 - $urandom_range(1, 4);
        end
        return $urandom;
    endfunction

    // Offers one item, with random idle cycles first, and waits until it is taken.
    task automatic send_item(input t_in_item item, input logic typed,
                             input t_out_item result);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_item    = item;
        typed_valid  = typed;
        typed_result = result;
        i_in_valid   = 1'b1;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
    endtask

    // Loads the element count once every expected result is back.
    task automatic load_elements(input logic [ELEMS_W-1:0] count);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (2) @(negedge i_clk);
        i_cfg_wdata = count;
        i_cfg_we    = 1'b1;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Output stall: random per cycle, plus one long hold-off on request.
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left   = hold_left - 1;
            i_out_stall = 1'b1;
        end else if (pressure_req && !pressure_done) begin
            pressure_done = 1'b1;
            hold_left     = PRESSURE_HOLD - 1;
            i_out_stall   = 1'b1;
        end else begin
            i_out_stall = ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Predicts accepted items and checks accepted results in handshake order.
    always @(posedge i_clk) begin : score_results
        t_out_item predicted;
        t_out_item wanted;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                elems_limit = 32'(i_cfg_wdata);
            end
            if (i_in_valid && !o_in_stall) begin
                predicted = unpool_apply(i_in_item);
                pending_results.push_back(typed_valid ? typed_result : predicted);
            end
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("unexpected result: read_bits %h status %b",
                                 o_out_item.read_bits, o_out_item.status);
                    end
                end else begin
                    wanted = pending_results.pop_front();
                    if (o_out_item.read_bits !== wanted.read_bits ||
                        o_out_item.status !== wanted.status) begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= REPORT_LIMIT) begin
                            $display("result mismatch: expected %h/%b, got %h/%b",
                                     wanted.read_bits, wanted.status,
                                     o_out_item.read_bits, o_out_item.status);
                        end
                    end
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == MAX_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : stimulus
        t_in_item         item;
        logic [ELEMS_W-1:0] count;
        int unsigned      bound;
        int unsigned      roll;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed table.
        for (int r = 0; r < DIRECTED_ROWS; r++) begin
            if (directed_rows[r].is_cfg) begin
                load_elements(directed_rows[r].value[ELEMS_W-1:0]);
            end else begin
                item.kind       = directed_rows[r].kind;
                item.flat_index = directed_rows[r].index;
                item.value_bits = directed_rows[r].value;
                send_item(item, directed_rows[r].typed, directed_rows[r].result);
            end
        end

        // Random phases, each under its own element count and idle pattern.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: count = 17'd65536;
                1: count = 17'd1;
                2: count = 17'd100;
                3: count = 17'd131071;
                4: count = 17'd0;
                5: count = 17'd4096;
                6: count = 17'd65535;
                default: count = 17'd17;
            endcase
            load_elements(count);
            bound = (32'(count) > STORE_DEPTH) ? STORE_DEPTH : 32'(count);
            @(posedge i_clk);
            case (p % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 46;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 46;
                end
                default: begin
                    send_idle_pct  = 27;
                    recv_stall_pct = 27;
                end
            endcase
            // The zero-count phase also carries the long output hold-off.
            if (p == 4) begin
                pressure_req = 1'b1;
            end
            // A few phases start from a freshly cleared store.
            if (p == 5 || p == 7) begin
                item.kind       = KIND_CLEAR;
                item.flat_index = $urandom;
                item.value_bits = $urandom;
                send_item(item, 1'b0, RES_OK);
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                roll            = $urandom_range(0, 99);
                item.kind       = (roll < 50) ? KIND_SCATTER :
                                  (roll < 96) ? KIND_READ : KIND_SPARE;
                item.flat_index = pick_index(bound);
                item.value_bits = $urandom;
                send_item(item, 1'b0, RES_OK);
            end
        end

        // Drain, then let the engine settle before the verdict.
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        mismatch_count = mismatch_count + pending_results.size();
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/mup_pkg.sv
design/mup_store.sv
design/mup_ctrl.sv
design/max_unpool_scatter.sv
design/mup_checker.sv
dv/testbench.sv
